>>> design/cns_pkg.sv
`default_nettype none
package cns_pkg;

  // Fixed sample format of both channels, Q1.15
  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS_DEF = 24;
  localparam int HOLD_BITS = 20;
  localparam int COEF_BITS = 18;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam int PINK_POLES = 6;
  localparam int PINK_TAPS = 7;

  typedef logic signed [COEF_BITS-1:0] cns_coef_t;

  // Pink filter poles and feeds, Q2.16
  localparam cns_coef_t POLE [PINK_POLES] = '{
    18'sd65461, 18'sd65098, 18'sd63504, 18'sd56787, 18'sd36045, -18'sd49912
  };
  localparam cns_coef_t FEED [PINK_POLES] = '{
    18'sd3638, 18'sd4920, 18'sd10083, 18'sd20348, 18'sd34928, -18'sd1107
  };
  localparam cns_coef_t K_DIRECT     = 18'sd35140;
  localparam cns_coef_t K_LAST       = 18'sd7597;
  localparam cns_coef_t K_PINK_OUT   = 18'sd11796;
  localparam cns_coef_t K_BROWN      = 18'sd1311;
  localparam cns_coef_t K_GREY_DAMP  = 18'sd26214;
  localparam cns_coef_t K_GREY_DEPTH = 18'sd49152;

  typedef enum logic [3:0] {
    COL_WHITE   = 4'd0,
    COL_PINK    = 4'd1,
    COL_BROWN   = 4'd2,
    COL_BLUE    = 4'd3,
    COL_VIOLET  = 4'd4,
    COL_GREY    = 4'd5,
    COL_BAND    = 4'd6,
    COL_WIND    = 4'd7,
    COL_DIGITAL = 4'd8
  } cns_colour_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COLOUR      = 3'd0,
    REG_BAND_COEF   = 3'd1,
    REG_BAND_DAMP   = 3'd2,
    REG_HOLD_RATE   = 3'd3,
    REG_HOLD_PERIOD = 3'd4,
    REG_GAIN_LEFT   = 3'd5,
    REG_GAIN_RIGHT  = 3'd6
  } cns_reg_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_FIN
  } cns_state_e;

  typedef struct packed {
    logic [3:0]  colour;
    logic [16:0] band_coef;
    logic [15:0] band_damp;
    logic [16:0] hold_rate;
    logic [17:0] hold_period;
    logic [15:0] gain_left;
    logic [15:0] gain_right;
  } cns_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] white_left;
    logic signed [SAMPLE_BITS-1:0] white_right;
    logic                          block_end;
  } cns_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_last;
  } cns_out_t;

  typedef struct packed {
    logic issue;
    logic start;
  } cns_mac_ctrl_t;

endpackage
`default_nettype wire

>>> design/coloured_noise_shaper.sv
// Coloured noise shaper.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one beat holding a
// left and right white sample plus a block-end flag. Output channel
// (out_valid_o/out_ready_i/out_data_o) returns one beat per input beat with
// the shaped, gain-scaled, saturated samples and the echoed flag.
// Configuration beats (cfg_valid_i/cfg_ready_o, index and data) are always
// taken; write them only while no sample is in flight.
// Each sample pair runs through one shared multiply-accumulate unit, left
// channel then right, under a step sequencer whose step count depends on the
// colour. A new beat is taken only once the previous result has moved to
// the output register, so the shaper works on one beat at a time.
// The output register holds a result while the receiver stalls; a second
// finished result waits inside the shaper and blocks new input.
// Reset clears all filter state and loads register defaults.
`default_nettype none
module coloured_noise_shaper #(
  parameter int STATE_BITS = cns_pkg::STATE_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire cns_pkg::cns_in_t                     in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output cns_pkg::cns_out_t                         out_data_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [cns_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [cns_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  cns_pkg::cns_cfg_t cfg_q;
  cns_pkg::cns_out_t out_q, res;
  logic              out_valid_q;
  logic              core_idle, res_valid, res_take, in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = core_idle;
  assign in_fire     = in_valid_i & in_ready_o;
  assign res_take    = res_valid & (~out_valid_q | out_ready_i);

  // Register writes, masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour      <= 4'd0;
      cfg_q.band_coef   <= 17'd0;
      cfg_q.band_damp   <= 16'd45875;
      cfg_q.hold_rate   <= 17'd1000;
      cfg_q.hold_period <= 18'd48000;
      cfg_q.gain_left   <= 16'd8192;
      cfg_q.gain_right  <= 16'd8192;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cns_pkg::REG_COLOUR:      cfg_q.colour      <= cfg_data_i[3:0];
        cns_pkg::REG_BAND_COEF:   cfg_q.band_coef   <= cfg_data_i[16:0];
        cns_pkg::REG_BAND_DAMP:   cfg_q.band_damp   <= cfg_data_i[15:0];
        cns_pkg::REG_HOLD_RATE:   cfg_q.hold_rate   <= cfg_data_i[16:0];
        cns_pkg::REG_HOLD_PERIOD: cfg_q.hold_period <= cfg_data_i[17:0];
        cns_pkg::REG_GAIN_LEFT:   cfg_q.gain_left   <= cfg_data_i[15:0];
        cns_pkg::REG_GAIN_RIGHT:  cfg_q.gain_right  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  cns_core #(
    .STATE_BITS(STATE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_fire),
    .in_i        (in_data_i),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Output register: load a finished beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("shaper took a beat while busy");

  a_no_accept_with_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("input ready while a result is pending");

  a_take_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_o)
    else $error("taken result missing from output register");

  a_take_frees_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> in_ready_o)
    else $error("shaper not idle after handing over result");

endmodule
`default_nettype wire

>>> design/cns_mac.sv
`default_nettype none
// Shared multiply-accumulate unit: one product per cycle, registered,
// then summed into the accumulator. Rounded views of the accumulator.
module cns_mac #(
  parameter int A_BITS   = 27,
  parameter int ACC_BITS = 47
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cns_pkg::cns_mac_ctrl_t            ctrl_i,
  input  wire logic signed [A_BITS-1:0]          a_i,
  input  wire logic signed [cns_pkg::COEF_BITS-1:0] b_i,
  output logic signed [ACC_BITS-1:0]             r16_o,
  output logic signed [ACC_BITS-1:0]             r13_o
);

  localparam int P_BITS = A_BITS + cns_pkg::COEF_BITS;

  logic signed [P_BITS-1:0]   prod_d, prod_q;
  logic signed [ACC_BITS-1:0] acc_q;
  logic                       issue_q, start_q;

  assign prod_d = a_i * b_i;

  // Track which products feed the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      issue_q <= ctrl_i.issue;
      start_q <= ctrl_i.start;
    end
  end

  // Register product, then accumulate or restart
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (issue_q) begin
      if (start_q) begin
        acc_q <= ACC_BITS'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_BITS'(prod_q);
      end
    end
  end

  // Round half up: floor of value plus half an LSB
  assign r16_o = (acc_q + (ACC_BITS'(1) <<< 15)) >>> 16;
  assign r13_o = (acc_q + (ACC_BITS'(1) <<< 12)) >>> 13;

endmodule
`default_nettype wire

>>> design/cns_core.sv
`default_nettype none
// Per-channel shaping sequencer: walks the steps of the selected colour,
// drives the shared MAC and writes back filter state.
module cns_core #(
  parameter int STATE_BITS = cns_pkg::STATE_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cns_pkg::cns_cfg_t cfg_i,
  input  wire logic              start_i,
  input  wire cns_pkg::cns_in_t  in_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  input  wire logic              res_take_i,
  output cns_pkg::cns_out_t      res_o
);

  localparam int SB   = cns_pkg::SAMPLE_BITS;
  localparam int ST   = STATE_BITS;
  localparam int PB   = SB + 2;
  localparam int HB   = cns_pkg::HOLD_BITS;
  localparam int AW   = ((ST > SB) ? ST : SB) + 3;
  localparam int ACCW = AW + 20;

  function automatic logic signed [ACCW-1:0] clip(input logic signed [ACCW-1:0] v,
                                                  input int bits);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = (ACCW'(1) <<< (bits - 1)) - ACCW'(1);
    lo = ~hi;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  cns_pkg::cns_state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       ch_q, ch_d;

  cns_pkg::cns_in_t win_q;
  logic signed [ST-1:0] taps_q  [2][cns_pkg::PINK_TAPS];
  logic signed [SB:0]   brown_q [2];
  logic signed [PB-1:0] prev_q  [2];
  logic signed [ST-1:0] i1_q    [2];
  logic signed [ST-1:0] i2_q    [2];
  logic signed [HB-1:0] cd_q    [2];
  logic signed [SB-1:0] held_q  [2];
  logic signed [AW-1:0] psum_q;
  logic signed [ST-1:0] hp_q;
  logic signed [AW-1:0] v_q;
  logic signed [SB-1:0] res_q   [2];

  cns_pkg::cns_colour_e   cls;
  logic [4:0]             vs;
  cns_pkg::cns_mac_ctrl_t mac_ctrl;
  logic signed [AW-1:0]   mac_a;
  cns_pkg::cns_coef_t     mac_b;
  cns_pkg::cns_coef_t     damp;
  logic signed [ACCW-1:0] r16, r13;

  logic signed [SB-1:0]   w;
  logic signed [ACCW-1:0] t_tap, t_brown, t_cds, t_cda, t_i2, t_hp, t_i1, t_p, t_out;
  logic signed [ST-1:0]   tap_n, i2_n, hp_n, i1_n;
  logic signed [SB:0]     brown_n;
  logic signed [HB-1:0]   cds_n, cda_n;
  logic signed [PB-1:0]   p_n;
  logic signed [SB-1:0]   out_n;
  logic signed [AW-1:0]   r16_a;
  logic [4:0]             s3;
  logic [2:0]             kw;

  assign w  = ch_q ? win_q.white_right : win_q.white_left;
  assign s3 = step_q - 5'd3;
  assign kw = s3[3:1];

  // Map the colour register; unused codes act as digital
  always_comb begin
    unique case (cfg_i.colour)
      cns_pkg::COL_WHITE:  cls = cns_pkg::COL_WHITE;
      cns_pkg::COL_PINK:   cls = cns_pkg::COL_PINK;
      cns_pkg::COL_BROWN:  cls = cns_pkg::COL_BROWN;
      cns_pkg::COL_BLUE:   cls = cns_pkg::COL_BLUE;
      cns_pkg::COL_VIOLET: cls = cns_pkg::COL_VIOLET;
      cns_pkg::COL_GREY:   cls = cns_pkg::COL_GREY;
      cns_pkg::COL_BAND:   cls = cns_pkg::COL_BAND;
      cns_pkg::COL_WIND:   cls = cns_pkg::COL_WIND;
      default:             cls = cns_pkg::COL_DIGITAL;
    endcase
  end

  // Step at which the shaped value is ready
  always_comb begin
    case (cls) inside
      cns_pkg::COL_PINK, cns_pkg::COL_BLUE:                   vs = 5'd17;
      cns_pkg::COL_BROWN:                                     vs = 5'd2;
      cns_pkg::COL_GREY:                                      vs = 5'd9;
      cns_pkg::COL_BAND, cns_pkg::COL_WIND:                   vs = 5'd6;
      default:                                                vs = 5'd0;
    endcase
  end

  assign damp = (cls == cns_pkg::COL_GREY) ? cns_pkg::K_GREY_DAMP
                                           : cns_pkg::cns_coef_t'({2'b00, cfg_i.band_damp});

  // Operand selection for the shared MAC
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    if (state_q == cns_pkg::CORE_RUN) begin
      case (cls) inside
        cns_pkg::COL_PINK, cns_pkg::COL_BLUE: begin
          if (step_q < 5'd12) begin
            mac_ctrl.issue = 1'b1;
            if (!step_q[0]) begin
              mac_ctrl.start = 1'b1;
              mac_a = AW'(taps_q[ch_q][step_q[3:1]]);
              mac_b = cns_pkg::POLE[step_q[3:1]];
            end else begin
              mac_a = AW'(w);
              mac_b = cns_pkg::FEED[step_q[3:1]];
            end
          end else if (step_q == 5'd12) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(w);
            mac_b = cns_pkg::K_DIRECT;
          end else if (step_q == 5'd13) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(w);
            mac_b = cns_pkg::K_LAST;
          end else if (step_q == 5'd15) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = psum_q;
            mac_b = cns_pkg::K_PINK_OUT;
          end
        end
        cns_pkg::COL_BROWN: begin
          if (step_q == 5'd0) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(w);
            mac_b = cns_pkg::K_BROWN;
          end
        end
        cns_pkg::COL_GREY, cns_pkg::COL_BAND, cns_pkg::COL_WIND: begin
          if (step_q == 5'd0) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(i1_q[ch_q]);
            mac_b = cns_pkg::cns_coef_t'({1'b0, cfg_i.band_coef});
          end else if (step_q == 5'd1) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(i1_q[ch_q]);
            mac_b = damp;
          end else if (step_q == 5'd4) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(hp_q);
            mac_b = cns_pkg::cns_coef_t'({1'b0, cfg_i.band_coef});
          end else if (step_q == 5'd7 && cls == cns_pkg::COL_GREY) begin
            mac_ctrl = '{issue: 1'b1, start: 1'b1};
            mac_a = AW'(i1_q[ch_q]);
            mac_b = cns_pkg::K_GREY_DEPTH;
          end
        end
        default: ;
      endcase
      // Channel gain
      if (step_q == vs + 5'd1) begin
        mac_ctrl = '{issue: 1'b1, start: 1'b1};
        mac_a = v_q;
        mac_b = ch_q ? cns_pkg::cns_coef_t'({2'b00, cfg_i.gain_right})
                     : cns_pkg::cns_coef_t'({2'b00, cfg_i.gain_left});
      end
    end
  end

  cns_mac #(
    .A_BITS  (AW),
    .ACC_BITS(ACCW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .r16_o  (r16),
    .r13_o  (r13)
  );

  // Write-back values, saturated to their stores
  always_comb begin
    r16_a   = $signed(r16[AW-1:0]);
    t_tap   = clip(r16, ST);
    tap_n   = $signed(t_tap[ST-1:0]);
    t_brown = ACCW'(brown_q[ch_q]) + r16;
    if (t_brown > (ACCW'(1) <<< (SB - 1))) begin
      t_brown = ACCW'(1) <<< (SB - 1);
    end else if (t_brown < -(ACCW'(1) <<< (SB - 1))) begin
      t_brown = -(ACCW'(1) <<< (SB - 1));
    end
    brown_n = $signed(t_brown[SB:0]);
    t_cds   = clip(ACCW'(cd_q[ch_q]) - ACCW'($signed({1'b0, cfg_i.hold_rate})), HB);
    cds_n   = $signed(t_cds[HB-1:0]);
    t_cda   = clip(t_cds + ACCW'($signed({1'b0, cfg_i.hold_period})), HB);
    cda_n   = $signed(t_cda[HB-1:0]);
    t_i2    = clip(ACCW'(i2_q[ch_q]) + r16, ST);
    i2_n    = $signed(t_i2[ST-1:0]);
    t_hp    = clip(ACCW'(w) - ACCW'(i2_q[ch_q]) - r16, ST);
    hp_n    = $signed(t_hp[ST-1:0]);
    t_i1    = clip(ACCW'(i1_q[ch_q]) + r16, ST);
    i1_n    = $signed(t_i1[ST-1:0]);
    t_p     = clip(r16, PB);
    p_n     = $signed(t_p[PB-1:0]);
    t_out   = clip(r13, SB);
    out_n   = $signed(t_out[SB-1:0]);
  end

  // Sequencer: left channel, then right, then hand over the result
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ch_d    = ch_q;
    unique case (state_q)
      cns_pkg::CORE_IDLE: begin
        if (start_i) begin
          state_d = cns_pkg::CORE_RUN;
          step_d  = '0;
          ch_d    = 1'b0;
        end
      end
      cns_pkg::CORE_RUN: begin
        if (step_q == vs + 5'd3) begin
          step_d = '0;
          if (!ch_q) begin
            ch_d = 1'b1;
          end else begin
            state_d = cns_pkg::CORE_FIN;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      cns_pkg::CORE_FIN: begin
        if (res_take_i) begin
          state_d = cns_pkg::CORE_IDLE;
        end
      end
      default: state_d = cns_pkg::CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cns_pkg::CORE_IDLE;
      step_q  <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ch_q    <= ch_d;
    end
  end

  // Latch the input beat
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      win_q <= in_i;
    end
  end

  // Filter state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < cns_pkg::PINK_TAPS; k++) begin
          taps_q[c][k] <= '0;
        end
        brown_q[c] <= '0;
        prev_q[c]  <= '0;
        i1_q[c]    <= '0;
        i2_q[c]    <= '0;
        cd_q[c]    <= '0;
        held_q[c]  <= '0;
      end
    end else if (state_q == cns_pkg::CORE_RUN) begin
      case (cls) inside
        cns_pkg::COL_PINK, cns_pkg::COL_BLUE: begin
          if (step_q[0] && step_q >= 5'd3 && step_q <= 5'd13) begin
            taps_q[ch_q][kw] <= tap_n;
          end
          if (step_q == 5'd15) begin
            taps_q[ch_q][cns_pkg::PINK_TAPS-1] <= tap_n;
          end
          if (step_q == 5'd17 && cls == cns_pkg::COL_BLUE) begin
            prev_q[ch_q] <= p_n;
          end
        end
        cns_pkg::COL_BROWN: begin
          if (step_q == 5'd2) begin
            brown_q[ch_q] <= brown_n;
          end
        end
        cns_pkg::COL_VIOLET: begin
          if (step_q == 5'd0) begin
            prev_q[ch_q] <= PB'(w);
          end
        end
        cns_pkg::COL_GREY, cns_pkg::COL_BAND, cns_pkg::COL_WIND: begin
          if (step_q == 5'd2) begin
            i2_q[ch_q] <= i2_n;
          end
          if (step_q == 5'd6) begin
            i1_q[ch_q] <= i1_n;
          end
        end
        cns_pkg::COL_DIGITAL: begin
          if (step_q == 5'd0) begin
            if (cds_n <= 0) begin
              cd_q[ch_q]   <= cda_n;
              held_q[ch_q] <= w;
            end else begin
              cd_q[ch_q] <= cds_n;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working values: pink sum, high pass, shaped value, channel result
  always_ff @(posedge clk_i) begin
    if (state_q == cns_pkg::CORE_RUN) begin
      case (cls) inside
        cns_pkg::COL_PINK, cns_pkg::COL_BLUE: begin
          if (step_q == 5'd0) begin
            psum_q <= AW'(taps_q[ch_q][cns_pkg::PINK_TAPS-1]);
          end else if (step_q[0] && step_q >= 5'd3 && step_q <= 5'd13) begin
            psum_q <= psum_q + AW'(tap_n);
          end else if (step_q == 5'd14) begin
            psum_q <= psum_q + r16_a;
          end
          if (step_q == 5'd17) begin
            if (cls == cns_pkg::COL_BLUE) begin
              v_q <= AW'(p_n) - AW'(prev_q[ch_q]);
            end else begin
              v_q <= AW'(p_n);
            end
          end
        end
        cns_pkg::COL_BROWN: begin
          if (step_q == 5'd2) begin
            v_q <= AW'(brown_n);
          end
        end
        cns_pkg::COL_WHITE: begin
          if (step_q == 5'd0) begin
            v_q <= AW'(w);
          end
        end
        cns_pkg::COL_VIOLET: begin
          if (step_q == 5'd0) begin
            v_q <= AW'(w) - AW'(prev_q[ch_q]);
          end
        end
        cns_pkg::COL_GREY, cns_pkg::COL_BAND, cns_pkg::COL_WIND: begin
          if (step_q == 5'd3) begin
            hp_q <= hp_n;
          end
          if (step_q == 5'd6) begin
            v_q <= AW'(i1_n);
          end
          if (step_q == 5'd9 && cls == cns_pkg::COL_GREY) begin
            v_q <= AW'(w) - r16_a;
          end
        end
        default: begin
          if (step_q == 5'd0) begin
            v_q <= (cds_n <= 0) ? AW'(w) : AW'(held_q[ch_q]);
          end
        end
      endcase
      if (step_q == vs + 5'd3) begin
        res_q[ch_q] <= out_n;
      end
    end
  end

  assign idle_o      = (state_q == cns_pkg::CORE_IDLE);
  assign res_valid_o = (state_q == cns_pkg::CORE_FIN);
  assign res_o       = '{left_sample:  res_q[0],
                         right_sample: res_q[1],
                         block_last:   win_q.block_end};

endmodule
`default_nettype wire
